>>> src/gipa_pkg.sv
// Shared constants and types for the grouped id pool allocator.
`timescale 1ns / 1ps

package gipa_pkg;

	localparam int MAX_IDS    = 64;
	localparam int NUM_GROUPS = 8;

	localparam int ID_W    = $clog2(MAX_IDS);
	localparam int CNT_W   = $clog2(MAX_IDS + 1);
	localparam int GRP_W   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int LIMIT_W = 7;
	localparam int CMP_W   = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

	// request queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic             op;
		logic [GRP_W-1:0] grp;
	} req_t;

endpackage

>>> src/gipa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gipa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/gipa_front.sv
// Request intake: classifies requests and buffers them in a short queue.
`timescale 1ns / 1ps

module gipa_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       kind,
	input  logic [gipa_pkg::GRP_W-1:0] group,
	output logic                       q_valid,
	output gipa_pkg::req_t             q_req,
	input  logic                       q_pop
);

	gipa_pkg::req_t                     slot_q [gipa_pkg::QDEPTH];
	logic [gipa_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [gipa_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [gipa_pkg::QCNT_W-1:0]        cnt_q;
	logic                               push;
	logic                               pop;
	gipa_pkg::req_t                     req_in;

	assign in_stall = (cnt_q == gipa_pkg::QCNT_W'(gipa_pkg::QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_req    = slot_q[rd_ptr_q];

	always_comb begin
		req_in.op  = kind ? gipa_pkg::OP_RELEASE : gipa_pkg::OP_ALLOC;
		req_in.grp = group;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == gipa_pkg::QPTR_W'(gipa_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == gipa_pkg::QPTR_W'(gipa_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> src/gipa_back.sv
// Execution engine: free stack, group lists, link memory and result register.
`timescale 1ns / 1ps

module gipa_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  gipa_pkg::req_t               q_req,
	output logic                         q_pop,
	input  logic                         cfg_we,
	input  logic [gipa_pkg::LIMIT_W-1:0] cfg_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [gipa_pkg::ID_W-1:0]    set_id,
	output logic                         fresh,
	output logic                         full_res,
	output logic [gipa_pkg::CNT_W-1:0]   released
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                         state_q;
	logic [gipa_pkg::LIMIT_W-1:0] pool_limit_q;
	logic [gipa_pkg::CNT_W-1:0]   minted_q;
	logic [gipa_pkg::ID_W-1:0]    free_top_q;
	logic [gipa_pkg::CNT_W-1:0]   free_cnt_q;
	logic [gipa_pkg::CNT_W-1:0]   grp_cnt_q  [gipa_pkg::NUM_GROUPS];
	logic [gipa_pkg::ID_W-1:0]    grp_head_q [gipa_pkg::NUM_GROUPS];
	logic [gipa_pkg::ID_W-1:0]    grp_tail_q [gipa_pkg::NUM_GROUPS];
	gipa_pkg::req_t               req_q;

	logic                         out_valid_q;
	logic [gipa_pkg::ID_W-1:0]    out_id_q;
	logic                         out_fresh_q;
	logic                         out_full_q;
	logic [gipa_pkg::CNT_W-1:0]   out_rel_q;

	logic                         out_free;
	logic                         exec_go;
	logic [gipa_pkg::ID_W-1:0]    link_rdata;
	logic [gipa_pkg::CMP_W-1:0]   limit_ext;
	logic [gipa_pkg::CMP_W-1:0]   limit_sat;
	logic [gipa_pkg::CNT_W-1:0]   cnt_cur;
	logic [gipa_pkg::ID_W-1:0]    head_cur;
	logic [gipa_pkg::ID_W-1:0]    tail_cur;

	logic                         res_fresh;
	logic                         res_full;
	logic [gipa_pkg::ID_W-1:0]    res_id;
	logic [gipa_pkg::CNT_W-1:0]   res_rel;
	logic                         ram_we;
	logic [gipa_pkg::ID_W-1:0]    ram_waddr;
	logic [gipa_pkg::ID_W-1:0]    ram_wdata;
	logic                         alloc_ok;
	logic [gipa_pkg::ID_W-1:0]    free_top_d;
	logic [gipa_pkg::CNT_W-1:0]   free_cnt_d;
	logic [gipa_pkg::CNT_W-1:0]   minted_d;
	logic [gipa_pkg::CNT_W-1:0]   cnt_d;

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign exec_go  = (state_q == ST_EXEC) && out_free;

	assign cnt_cur  = grp_cnt_q[req_q.grp];
	assign head_cur = grp_head_q[req_q.grp];
	assign tail_cur = grp_tail_q[req_q.grp];

	// limit above the id space saturates
	assign limit_ext = gipa_pkg::CMP_W'(pool_limit_q);
	assign limit_sat = (limit_ext > gipa_pkg::CMP_W'(gipa_pkg::MAX_IDS)) ?
		gipa_pkg::CMP_W'(gipa_pkg::MAX_IDS) : limit_ext;

	// link memory is read at the stack top every cycle; the data lines up
	// with the execute cycle since the top only moves there
	gipa_ram #(
		.WIDTH (gipa_pkg::ID_W),
		.DEPTH (gipa_pkg::MAX_IDS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (free_top_q),
		.rdata (link_rdata)
	);

	always_comb begin
		res_id     = '0;
		res_fresh  = 1'b0;
		res_full   = 1'b0;
		res_rel    = '0;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = '0;
		alloc_ok   = 1'b0;
		free_top_d = free_top_q;
		free_cnt_d = free_cnt_q;
		minted_d   = minted_q;
		cnt_d      = cnt_cur;
		unique case (req_q.op)
			gipa_pkg::OP_ALLOC: begin
				if (free_cnt_q != '0) begin
					// recycle the top of the free stack
					res_id     = free_top_q;
					free_top_d = link_rdata;
					free_cnt_d = free_cnt_q - 1'b1;
					alloc_ok   = 1'b1;
				end else if (gipa_pkg::CMP_W'(minted_q) < limit_sat) begin
					res_id    = minted_q[gipa_pkg::ID_W-1:0];
					minted_d  = minted_q + 1'b1;
					res_fresh = 1'b1;
					alloc_ok  = 1'b1;
				end else begin
					res_full = 1'b1;
				end
				if (alloc_ok) begin
					ram_we    = exec_go;
					ram_waddr = res_id;
					ram_wdata = (cnt_cur == '0) ? '0 : tail_cur;
					cnt_d     = cnt_cur + 1'b1;
				end
			end
			gipa_pkg::OP_RELEASE: begin
				if (cnt_cur != '0) begin
					// splice the whole group on top of the free stack
					ram_we     = exec_go;
					ram_waddr  = head_cur;
					ram_wdata  = (free_cnt_q != '0) ? free_top_q : '0;
					free_top_d = tail_cur;
					free_cnt_d = free_cnt_q + cnt_cur;
					res_rel    = cnt_cur;
					cnt_d      = '0;
				end
			end
			default: begin
				res_id = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pool_limit_q <= gipa_pkg::LIMIT_RESET;
			minted_q     <= '0;
			free_top_q   <= '0;
			free_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < gipa_pkg::NUM_GROUPS; i++) begin
				grp_cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				pool_limit_q <= cfg_data;
			end
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q              <= ST_IDLE;
						minted_q             <= minted_d;
						free_top_q           <= free_top_d;
						free_cnt_q           <= free_cnt_d;
						grp_cnt_q[req_q.grp] <= cnt_d;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			req_q <= q_req;
		end
		if (exec_go) begin
			out_id_q    <= res_id;
			out_fresh_q <= res_fresh;
			out_full_q  <= res_full;
			out_rel_q   <= res_rel;
			if (req_q.op == gipa_pkg::OP_ALLOC && alloc_ok) begin
				grp_tail_q[req_q.grp] <= res_id;
				if (cnt_cur == '0) begin
					grp_head_q[req_q.grp] <= res_id;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign set_id    = out_id_q;
	assign fresh     = out_fresh_q;
	assign full_res  = out_full_q;
	assign released  = out_rel_q;

`ifndef SYNTHESIS
	a_we_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_EXEC)
		else $error("link memory written outside execute");
	a_exec_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && !out_free) |=> state_q == ST_EXEC && $stable(req_q))
		else $error("execute left while result register blocked");
	a_minted_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> minted_q >= $past(minted_q))
		else $error("minted count went down");
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= minted_q)
		else $error("more free ids than minted ids");
	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EXEC)
		else $error("result appeared without execute cycle");
`endif

endmodule

>>> src/grouped_id_pool_allocator_unit.sv
// Top level of the grouped id pool allocator: intake queue plus execution engine.
// Engine takes each request from the queue in its idle state while link memory is read
// at the free stack top, then does list update and result load in its execute state;
// it takes no new request before that. Requests pass the queue, req_q and the result
// register; a stalled result holds the engine, and 2 more requests may wait in queue.
// Async active-low reset empties queue and result register, clears counts, pool_limit 64.
`timescale 1ns / 1ps

module grouped_id_pool_allocator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         kind,
	input  logic [gipa_pkg::GRP_W-1:0]   group,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [gipa_pkg::ID_W-1:0]    set_id,
	output logic                         fresh,
	output logic                         full_res,
	output logic [gipa_pkg::CNT_W-1:0]   released,
	// pool_limit register write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [gipa_pkg::LIMIT_W-1:0] pool_limit
);

	logic           q_valid;
	logic           q_pop;
	gipa_pkg::req_t q_req;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	// front end: accepts and classifies each request, queues it
	gipa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.group    (group),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop)
	);

	// back end: free stack pop/mint, group append, group release splice
	gipa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (pool_limit),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.set_id    (set_id),
		.fresh     (fresh),
		.full_res  (full_res),
		.released  (released)
	);

endmodule

>>> verif/tb_grouped_id_pool_allocator_unit.sv
// Testbench for the grouped id pool allocator: directed and random requests vs a predictor.
`timescale 1ns / 1ps

module tb_grouped_id_pool_allocator_unit;

	// overall cycle budget
	localparam int CYCLE_LIMIT = 300000;
	// length of the one long receiver hold-off that backs the block up
	localparam int HOLD_LEN    = 200;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 165;

	// one result as the block reports it
	typedef struct packed {
		logic [gipa_pkg::ID_W-1:0]  id;
		logic                       fresh;
		logic                       full;
		logic [gipa_pkg::CNT_W-1:0] rel;
	} alloc_res_t;

	// one step of the directed part: either a pool_limit write or a request,
	// the latter optionally carrying its expected result typed in by hand
	typedef struct packed {
		bit                           wr_lim;
		logic [gipa_pkg::LIMIT_W-1:0] lim_val;
		logic                         op;
		logic [gipa_pkg::GRP_W-1:0]   grp;
		bit                           typed;
		alloc_res_t                   res;
	} dir_step_t;

	localparam int DIR_LEN = 27;
	localparam dir_step_t DIR_STEPS [DIR_LEN] = '{
		// fresh out of reset: empty release, then ids minted in order
		'{0, 0,   gipa_pkg::OP_RELEASE, 0, 1, '{0, 0, 0, 0}},
		'{0, 0,   gipa_pkg::OP_ALLOC,   0, 1, '{0, 1, 0, 0}},
		'{0, 0,   gipa_pkg::OP_ALLOC,   7, 1, '{1, 1, 0, 0}},
		'{0, 0,   gipa_pkg::OP_ALLOC,   7, 1, '{2, 1, 0, 0}},
		'{0, 0,   gipa_pkg::OP_RELEASE, 7, 1, '{0, 0, 0, 2}},
		// recycled ids come back newest first, then minting resumes
		'{0, 0,   gipa_pkg::OP_ALLOC,   3, 0, '0},
		'{0, 0,   gipa_pkg::OP_ALLOC,   3, 0, '0},
		'{0, 0,   gipa_pkg::OP_ALLOC,   3, 0, '0},
		'{0, 0,   gipa_pkg::OP_RELEASE, 3, 0, '0},
		'{0, 0,   gipa_pkg::OP_RELEASE, 0, 0, '0},
		// limit of zero: only recycled ids, then full
		'{1, 0,   gipa_pkg::OP_ALLOC,   0, 0, '0},
		'{0, 0,   gipa_pkg::OP_ALLOC,   5, 0, '0},
		'{0, 0,   gipa_pkg::OP_ALLOC,   5, 0, '0},
		'{0, 0,   gipa_pkg::OP_ALLOC,   5, 0, '0},
		'{0, 0,   gipa_pkg::OP_ALLOC,   5, 0, '0},
		'{0, 0,   gipa_pkg::OP_ALLOC,   5, 1, '{0, 0, 1, 0}},
		'{0, 0,   gipa_pkg::OP_RELEASE, 5, 0, '0},
		// limit above the pool size saturates
		'{1, 127, gipa_pkg::OP_ALLOC,   0, 0, '0},
		'{0, 0,   gipa_pkg::OP_ALLOC,   2, 0, '0},
		'{0, 0,   gipa_pkg::OP_ALLOC,   4, 0, '0},
		'{0, 0,   gipa_pkg::OP_ALLOC,   4, 0, '0},
		'{0, 0,   gipa_pkg::OP_ALLOC,   4, 0, '0},
		'{0, 0,   gipa_pkg::OP_ALLOC,   4, 0, '0},
		// limit dropped below the minted count: stack empty means full
		'{1, 1,   gipa_pkg::OP_ALLOC,   0, 0, '0},
		'{0, 0,   gipa_pkg::OP_ALLOC,   1, 1, '{0, 0, 1, 0}},
		'{0, 0,   gipa_pkg::OP_RELEASE, 4, 0, '0},
		'{0, 0,   gipa_pkg::OP_RELEASE, 2, 0, '0}
	};

	// random phases: limit written first, then a mix biased toward allocation in all but the last
	localparam logic [gipa_pkg::LIMIT_W-1:0] PH_LIMIT [PHASES] =
		'{1, 3, 0, 8, 127, 20, 5, 64, 0, 64};
	localparam int PH_ALLOC_PCT [PHASES] = '{70, 75, 60, 75, 92, 70, 65, 85, 60, 50};

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic                           kind;
	logic [gipa_pkg::GRP_W-1:0]     group;
	logic                           out_valid;
	logic                           out_stall;
	logic [gipa_pkg::ID_W-1:0]      set_id;
	logic                           fresh;
	logic                           full_res;
	logic [gipa_pkg::CNT_W-1:0]     released;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [gipa_pkg::LIMIT_W-1:0]   pool_limit;

	// typed expectation travels alongside the request it belongs to
	bit                             fixed_valid;
	alloc_res_t                     fixed_res;

	// idle rates of both sides, and the long hold-off trigger
	int                             snd_pct = 0;
	int                             rcv_pct = 0;
	int                             hold_reqs = 0;
	int                             hold_seen = 0;
	int                             hold_left = 0;

	int                             fails = 0;
	int                             cycles = 0;

	// predictor state: mirrors the allocator's counters and linked lists
	int                             lim_reg = 64;
	int                             minted = 0;
	logic [gipa_pkg::ID_W-1:0]      stack_top = '0;
	int                             stack_depth = 0;
	logic [gipa_pkg::ID_W-1:0]      link_mem [gipa_pkg::MAX_IDS];
	logic [gipa_pkg::ID_W-1:0]      grp_head [gipa_pkg::NUM_GROUPS];
	logic [gipa_pkg::ID_W-1:0]      grp_tail [gipa_pkg::NUM_GROUPS];
	int                             grp_cnt [gipa_pkg::NUM_GROUPS] = '{default: 0};

	// results owed by the block, oldest first
	alloc_res_t                     pending_results [$];

	grouped_id_pool_allocator_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.group      (group),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.set_id     (set_id),
		.fresh      (fresh),
		.full_res   (full_res),
		.released   (released),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.pool_limit (pool_limit)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Serve one request against the predictor state and return its result.
	// Allocation pops the free stack, else mints below the saturated limit,
	// else reports full. Release splices the group's list onto the stack so
	// that the group's newest id ends up on top.
	function automatic alloc_res_t serve_request(input logic op,
			input logic [gipa_pkg::GRP_W-1:0] g);
		alloc_res_t r;
		int cap;
		r = '0;
		if (op == gipa_pkg::OP_ALLOC) begin
			cap = (lim_reg > gipa_pkg::MAX_IDS) ? gipa_pkg::MAX_IDS : lim_reg;
			if (stack_depth > 0) begin
				r.id = stack_top;
				stack_top = link_mem[stack_top];
				stack_depth--;
			end else if (minted < cap) begin
				r.id = gipa_pkg::ID_W'(minted);
				r.fresh = 1'b1;
				minted++;
			end else begin
				r.full = 1'b1;
			end
			if (!r.full) begin
				if (grp_cnt[g] == 0) begin
					grp_head[g] = r.id;
					link_mem[r.id] = '0;
				end else begin
					link_mem[r.id] = grp_tail[g];
				end
				grp_tail[g] = r.id;
				grp_cnt[g]++;
			end
		end else if (grp_cnt[g] > 0) begin
			// oldest id of the group now sits on the old stack top
			link_mem[grp_head[g]] = (stack_depth > 0) ? stack_top : '0;
			stack_top = grp_tail[g];
			stack_depth += grp_cnt[g];
			r.rel = gipa_pkg::CNT_W'(grp_cnt[g]);
			grp_cnt[g] = 0;
		end
		return r;
	endfunction

	// Offer one request after a random idle gap and hold it until accepted.
	// Returns at the accepting edge with in_valid still high.
	task automatic offer(input logic op, input logic [gipa_pkg::GRP_W-1:0] g,
			input bit typed, input alloc_res_t r);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < snd_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= op;
		group       <= g;
		fixed_valid <= typed;
		fixed_res   <= r;
		do @(posedge clk); while (in_stall);
	endtask

	// Let every owed result come out, then stay idle so the engine is surely quiet.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// pool_limit is only rewritten with the block idle
	task automatic write_limit(input logic [gipa_pkg::LIMIT_W-1:0] v);
		drain();
		cfg_valid  <= 1'b1;
		pool_limit <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
	endtask

	// Receiver: random stalls at the phase's rate, or a long hold-off when
	// the stimulus asks for one; the hold is counted down here.
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_pct);
		end
	end

	// Monitor: register writes and accepted requests feed the predictor,
	// accepted results are checked against the oldest expectation.
	always @(posedge clk) begin
		alloc_res_t model;
		alloc_res_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				lim_reg = int'(pool_limit);
			if (in_valid && !in_stall) begin
				model = serve_request(kind, group);
				pending_results = {pending_results, (fixed_valid ? fixed_res : model)};
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result with none expected: set_id %0d fresh %0b %s %0d",
						set_id, fresh, $sformatf("full_res %0b released", full_res),
						released);
					fails++;
				end else begin
					want = pending_results.pop_front();
					if (set_id !== want.id) begin
						$error("set_id: expected %0d, got %0d", want.id, set_id);
						fails++;
					end
					if (fresh !== want.fresh) begin
						$error("fresh: expected %0b, got %0b", want.fresh, fresh);
						fails++;
					end
					if (full_res !== want.full) begin
						$error("full_res: expected %0b, got %0b", want.full, full_res);
						fails++;
					end
					if (released !== want.rel) begin
						$error("released: expected %0d, got %0d", want.rel, released);
						fails++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_grouped_id_pool_allocator_unit NOT OK");
			$finish;
		end
	end

	initial begin
		int ph;
		int n;
		logic op;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		kind        <= gipa_pkg::OP_ALLOC;
		group       <= '0;
		cfg_valid   <= 1'b0;
		pool_limit  <= gipa_pkg::LIMIT_RESET;
		fixed_valid <= 1'b0;
		fixed_res   <= '0;
		out_stall   <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		for (n = 0; n < DIR_LEN; n++) begin
			if (DIR_STEPS[n].wr_lim)
				write_limit(DIR_STEPS[n].lim_val);
			else
				offer(DIR_STEPS[n].op, DIR_STEPS[n].grp, DIR_STEPS[n].typed,
					DIR_STEPS[n].res);
		end

		// random part: idle mode rotates none / sender / receiver / both
		for (ph = 0; ph < PHASES; ph++) begin
			write_limit(PH_LIMIT[ph]);
			case (ph % 4)
				0: begin
					snd_pct = 0;
					rcv_pct = 0;
				end
				1: begin
					snd_pct = 46;
					rcv_pct = 0;
				end
				2: begin
					snd_pct = 0;
					rcv_pct = 46;
				end
				default: begin
					snd_pct = 8;
					rcv_pct = 8;
				end
			endcase
			// sender keeps pushing through a long receiver hold-off so the
			// queue fills and in_stall has to rise
			if (ph == 4)
				hold_reqs++;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				op = ($urandom_range(99) < PH_ALLOC_PCT[ph]) ?
					gipa_pkg::OP_ALLOC : gipa_pkg::OP_RELEASE;
				offer(op, gipa_pkg::GRP_W'($urandom_range(gipa_pkg::NUM_GROUPS - 1)),
					1'b0, '0);
			end
		end

		drain();
		if (fails == 0)
			$display("tb_grouped_id_pool_allocator_unit OK");
		else
			$display("tb_grouped_id_pool_allocator_unit NOT OK");
		$finish;
	end

endmodule
